// File: hw/rtl/sblc_pkg.sv
`default_nettype none
package sblc_pkg;

  localparam int KeyW   = 32;
  localparam int TotW   = 36;
  localparam int StampW = 64;
  localparam int OpW    = 4;

  localparam logic [1:0] REQ_GET = 2'd0;
  localparam logic [1:0] REQ_PUT = 2'd1;
  localparam logic [1:0] REQ_INV = 2'd2;

  localparam logic [OpW-1:0] OP_NONE       = 4'd0;
  localparam logic [OpW-1:0] OP_LATCH      = 4'd1;
  localparam logic [OpW-1:0] OP_SCAN_START = 4'd2;
  localparam logic [OpW-1:0] OP_RD         = 4'd3;
  localparam logic [OpW-1:0] OP_MATCH_CHK  = 4'd4;
  localparam logic [OpW-1:0] OP_MIN_CHK    = 4'd5;
  localparam logic [OpW-1:0] OP_RD_LAST    = 4'd6;
  localparam logic [OpW-1:0] OP_REMOVE     = 4'd7;
  localparam logic [OpW-1:0] OP_EMIT_EVICT = 4'd8;
  localparam logic [OpW-1:0] OP_EMIT_FAIL  = 4'd9;
  localparam logic [OpW-1:0] OP_GET_HIT    = 4'd10;
  localparam logic [OpW-1:0] OP_PUT_UPD    = 4'd11;
  localparam logic [OpW-1:0] OP_PUT_APP    = 4'd12;
  localparam logic [OpW-1:0] OP_EMIT_OK    = 4'd13;

  typedef struct packed {
    logic [KeyW-1:0]   key;
    logic [KeyW-1:0]   hash;
    logic [KeyW-1:0]   size;
    logic [StampW-1:0] stamp;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

  typedef struct packed {
    logic [OpW-1:0] op;
  } cmd_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       size_zero;
    logic       need_evict;
    logic       key_hit;
    logic       scan_end;
    logic       full;
    logic       found;
    logic       out_free;
  } stat_t;

endpackage
`default_nettype wire

// File: hw/rtl/sblc_ram.sv
`default_nettype none
module sblc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    we_i,
  input  wire logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                        wdata_i,
  input  wire logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic      [Width-1:0]                        rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

// File: hw/rtl/sblc_ctrl.sv
`default_nettype none
module sblc_ctrl
  import sblc_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_stall_o,
  input  wire stat_t stat_i,
  output cmd_t       cmd_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DISP   = 4'd1;
  localparam logic [3:0] S_FAIL   = 4'd2;
  localparam logic [3:0] S_PCHK   = 4'd3;
  localparam logic [3:0] S_LKRD   = 4'd4;
  localparam logic [3:0] S_LKCHK  = 4'd5;
  localparam logic [3:0] S_LKDONE = 4'd6;
  localparam logic [3:0] S_EVRD   = 4'd7;
  localparam logic [3:0] S_EVCHK  = 4'd8;
  localparam logic [3:0] S_RMLAST = 4'd9;
  localparam logic [3:0] S_RMDO   = 4'd10;
  localparam logic [3:0] S_EVEMIT = 4'd11;
  localparam logic [3:0] S_INVOK  = 4'd12;
  localparam logic [3:0] S_GETHIT = 4'd13;
  localparam logic [3:0] S_PUPD   = 4'd14;
  localparam logic [3:0] S_PAPP   = 4'd15;

  logic [3:0] state_q, state_d;
  logic       evfull_q, evfull_d;
  logic       rminv_q, rminv_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d  = state_q;
    evfull_d = evfull_q;
    rminv_d  = rminv_q;
    cmd_o.op = OP_NONE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LATCH;
          state_d  = S_DISP;
        end
      end
      S_DISP: begin
        case (stat_i.req_type)
          REQ_GET, REQ_INV: begin
            cmd_o.op = OP_SCAN_START;
            state_d  = S_LKRD;
          end
          REQ_PUT: state_d = stat_i.size_zero ? S_FAIL : S_PCHK;
          default: state_d = S_FAIL;
        endcase
      end
      S_FAIL: begin
        if (stat_i.out_free) begin
          cmd_o.op = OP_EMIT_FAIL;
          state_d  = S_IDLE;
        end
      end
      S_PCHK: begin
        cmd_o.op = OP_SCAN_START;
        if (stat_i.need_evict) begin
          evfull_d = 1'b0;
          rminv_d  = 1'b0;
          state_d  = S_EVRD;
        end else begin
          state_d = S_LKRD;
        end
      end
      S_LKRD: begin
        if (stat_i.scan_end) begin
          state_d = S_LKDONE;
        end else begin
          cmd_o.op = OP_RD;
          state_d  = S_LKCHK;
        end
      end
      S_LKCHK: begin
        cmd_o.op = OP_MATCH_CHK;
        state_d  = stat_i.key_hit ? S_LKDONE : S_LKRD;
      end
      S_LKDONE: begin
        case (stat_i.req_type)
          REQ_GET: state_d = stat_i.found ? S_GETHIT : S_FAIL;
          REQ_INV: begin
            rminv_d = 1'b1;
            state_d = stat_i.found ? S_RMLAST : S_FAIL;
          end
          REQ_PUT: begin
            if (stat_i.found) begin
              state_d = S_PUPD;
            end else if (stat_i.full) begin
              cmd_o.op = OP_SCAN_START;
              evfull_d = 1'b1;
              rminv_d  = 1'b0;
              state_d  = S_EVRD;
            end else begin
              state_d = S_PAPP;
            end
          end
          default: state_d = S_FAIL;
        endcase
      end
      S_EVRD: begin
        if (stat_i.scan_end) begin
          state_d = S_RMLAST;
        end else begin
          cmd_o.op = OP_RD;
          state_d  = S_EVCHK;
        end
      end
      S_EVCHK: begin
        cmd_o.op = OP_MIN_CHK;
        state_d  = S_EVRD;
      end
      S_RMLAST: begin
        cmd_o.op = OP_RD_LAST;
        state_d  = S_RMDO;
      end
      S_RMDO: begin
        cmd_o.op = OP_REMOVE;
        state_d  = rminv_q ? S_INVOK : S_EVEMIT;
      end
      S_EVEMIT: begin
        if (stat_i.out_free) begin
          cmd_o.op = OP_EMIT_EVICT;
          state_d  = evfull_q ? S_PAPP : S_PCHK;
        end
      end
      S_INVOK: begin
        if (stat_i.out_free) begin
          cmd_o.op = OP_EMIT_OK;
          state_d  = S_IDLE;
        end
      end
      S_GETHIT: begin
        if (stat_i.out_free) begin
          cmd_o.op = OP_GET_HIT;
          state_d  = S_IDLE;
        end
      end
      S_PUPD: begin
        if (stat_i.out_free) begin
          cmd_o.op = OP_PUT_UPD;
          state_d  = S_IDLE;
        end
      end
      S_PAPP: begin
        if (stat_i.out_free) begin
          cmd_o.op = OP_PUT_APP;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      evfull_q <= 1'b0;
      rminv_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      evfull_q <= evfull_d;
      rminv_q  <= rminv_d;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/sblc_dp.sv
`default_nettype none
module sblc_dp
  import sblc_pkg::*;
#(
  parameter int MaxEntries = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cmd_t              cmd_i,
  output stat_t                  stat_o,
  input  wire logic              cfg_we_i,
  input  wire logic [31:0]       cfg_wdata_i,
  output logic      [31:0]       limit_o,
  input  wire logic [1:0]        req_type_i,
  input  wire logic [KeyW-1:0]   key_i,
  input  wire logic [KeyW-1:0]   entry_hash_i,
  input  wire logic [KeyW-1:0]   entry_size_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic                   is_eviction_o,
  output logic      [KeyW-1:0]   out_key_o,
  output logic                   ok_o,
  output logic      [KeyW-1:0]   out_hash_o,
  output logic      [KeyW-1:0]   out_size_o,
  output logic      [TotW-1:0]   total_used_o,
  output logic      [4:0]        used_entries_o,
  output logic                   last_o
);

  localparam int CW = $clog2(MaxEntries + 1);
  localparam int AW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;

  logic [1:0]        req_q;
  logic [KeyW-1:0]   key_q, hash_q, size_q;
  logic [KeyW-1:0]   cap_key_q, cap_hash_q, cap_size_q;
  logic [StampW-1:0] min_q;
  logic [AW-1:0]     tgt_q;
  logic [31:0]       limit_q, limit_d;
  logic [CW-1:0]     count_q, count_d, scan_q, scan_d;
  logic [TotW-1:0]   total_q, total_d;
  logic [StampW-1:0] clock_q, clock_d;
  logic              found_q, found_d;
  logic              ov_q, ov_d;

  logic              we;
  logic [AW-1:0]     waddr, raddr;
  entry_t            wdata, rd;
  logic [EntryW-1:0] rdata;
  logic              emit;
  logic [TotW:0]     need_sum;

  sblc_ram #(.Width(EntryW), .Depth(MaxEntries)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign rd       = entry_t'(rdata);
  assign need_sum = {1'b0, total_q} + {5'b0, size_q};

  assign stat_o.req_type   = req_q;
  assign stat_o.size_zero  = (size_q == '0);
  assign stat_o.need_evict = (need_sum > {5'b0, limit_q}) && (count_q != '0);
  assign stat_o.key_hit    = (rd.key == key_q);
  assign stat_o.scan_end   = (scan_q == count_q);
  assign stat_o.full       = (count_q >= CW'(MaxEntries));
  assign stat_o.found      = found_q;
  assign stat_o.out_free   = !ov_q || !out_stall_i;

  assign limit_o = limit_q;

  always_comb begin
    we      = 1'b0;
    waddr   = tgt_q;
    raddr   = scan_q[AW-1:0];
    wdata   = '{key: key_q, hash: hash_q, size: size_q, stamp: clock_q};
    limit_d = cfg_we_i ? cfg_wdata_i : limit_q;
    count_d = count_q;
    total_d = total_q;
    clock_d = clock_q;
    scan_d  = scan_q;
    found_d = found_q;
    emit    = 1'b0;
    case (cmd_i.op)
      OP_SCAN_START: begin
        scan_d  = '0;
        found_d = 1'b0;
      end
      OP_MATCH_CHK, OP_MIN_CHK: scan_d = CW'(scan_q + 1'b1);
      OP_RD_LAST:   raddr = AW'(count_q - 1'b1);
      OP_REMOVE: begin
        we      = 1'b1;
        wdata   = rd;
        total_d = total_q - TotW'(cap_size_q);
        count_d = CW'(count_q - 1'b1);
      end
      OP_EMIT_EVICT, OP_EMIT_FAIL, OP_EMIT_OK: emit = 1'b1;
      OP_GET_HIT: begin
        we      = 1'b1;
        wdata   = '{key: cap_key_q, hash: cap_hash_q, size: cap_size_q, stamp: clock_q};
        clock_d = clock_q + 1'b1;
        emit    = 1'b1;
      end
      OP_PUT_UPD: begin
        we      = 1'b1;
        clock_d = clock_q + 1'b1;
        total_d = total_q - TotW'(cap_size_q) + TotW'(size_q);
        emit    = 1'b1;
      end
      OP_PUT_APP: begin
        we      = 1'b1;
        waddr   = AW'(count_q);
        clock_d = clock_q + 1'b1;
        total_d = total_q + TotW'(size_q);
        count_d = CW'(count_q + 1'b1);
        emit    = 1'b1;
      end
      default: ;
    endcase
    if (cmd_i.op == OP_MATCH_CHK && stat_o.key_hit) begin
      found_d = 1'b1;
    end
    ov_d = emit ? 1'b1 : (out_stall_i ? ov_q : 1'b0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= '1;
      count_q <= '0;
      total_q <= '0;
      clock_q <= '0;
      scan_q  <= '0;
      found_q <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      limit_q <= limit_d;
      count_q <= count_d;
      total_q <= total_d;
      clock_q <= clock_d;
      scan_q  <= scan_d;
      found_q <= found_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LATCH) begin
      req_q  <= req_type_i;
      key_q  <= key_i;
      hash_q <= entry_hash_i;
      size_q <= entry_size_i;
    end
    if ((cmd_i.op == OP_MATCH_CHK && stat_o.key_hit) ||
        (cmd_i.op == OP_MIN_CHK && (scan_q == '0 || rd.stamp < min_q))) begin
      tgt_q      <= scan_q[AW-1:0];
      min_q      <= rd.stamp;
      cap_key_q  <= rd.key;
      cap_hash_q <= rd.hash;
      cap_size_q <= rd.size;
    end
    if (emit) begin
      is_eviction_o  <= (cmd_i.op == OP_EMIT_EVICT);
      out_key_o      <= (cmd_i.op == OP_EMIT_EVICT) ? cap_key_q : key_q;
      ok_o           <= (cmd_i.op != OP_EMIT_EVICT) && (cmd_i.op != OP_EMIT_FAIL);
      out_hash_o     <= (cmd_i.op == OP_GET_HIT) ? cap_hash_q : '0;
      out_size_o     <= (cmd_i.op == OP_GET_HIT) ? cap_size_q : '0;
      total_used_o   <= total_d;
      used_entries_o <= 5'(count_d);
      last_o         <= (cmd_i.op != OP_EMIT_EVICT);
    end
  end

  assign out_valid_o = ov_q;

endmodule
`default_nettype wire

// File: hw/rtl/size_budget_lru_cache_index.sv
// Size-budget LRU cache index. Requests (get, put, invalidate) transfer one
// at a time; each yields zero or more eviction notices followed by one
// completion marked last. All entry storage lives in a single RAM with a
// registered read, and each table scan reads and then checks the valid
// entries one at a time. A put may scan the table again after an eviction
// it causes, and output stalls hold off the remaining steps. The byte budget
// register sits at byte address 0 and should be written only when idle.
`default_nettype none
module size_budget_lru_cache_index
  import sblc_pkg::*;
#(
  parameter int MAX_ENTRIES = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [1:0]        req_type_i,
  input  wire logic [KeyW-1:0]   key_i,
  input  wire logic [KeyW-1:0]   entry_hash_i,
  input  wire logic [KeyW-1:0]   entry_size_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic                   is_eviction_o,
  output logic      [KeyW-1:0]   out_key_o,
  output logic                   ok_o,
  output logic      [KeyW-1:0]   out_hash_o,
  output logic      [KeyW-1:0]   out_size_o,
  output logic      [TotW-1:0]   total_used_o,
  output logic      [4:0]        used_entries_o,
  output logic                   last_o
);

  cmd_t        cmd;
  stat_t       stat;
  logic        cfg_we;
  logic [31:0] limit;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? limit : '0;

  sblc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  sblc_dp #(.MaxEntries(MAX_ENTRIES)) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (pwdata),
    .limit_o        (limit),
    .req_type_i     (req_type_i),
    .key_i          (key_i),
    .entry_hash_i   (entry_hash_i),
    .entry_size_i   (entry_size_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .is_eviction_o  (is_eviction_o),
    .out_key_o      (out_key_o),
    .ok_o           (ok_o),
    .out_hash_o     (out_hash_o),
    .out_size_o     (out_size_o),
    .total_used_o   (total_used_o),
    .used_entries_o (used_entries_o),
    .last_o         (last_o)
  );

endmodule
`default_nettype wire

// File: hw/rtl/sblc_checker.sv
`default_nettype none
module sblc_checker #(
  parameter int MAX_ENTRIES = 16
) (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic       is_eviction_o,
  input wire logic       ok_o,
  input wire logic [31:0] out_hash_o,
  input wire logic [4:0] used_entries_o,
  input wire logic       last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o) else $error("result dropped");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o) else $error("not busy after transfer");

  a_notice: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_eviction_o |-> !ok_o && !last_o && out_hash_o == '0)
    else $error("bad eviction notice");

  a_nonlast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> is_eviction_o) else $error("non-final completion");

  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(used_entries_o) <= MAX_ENTRIES) else $error("count overflow");

endmodule

bind size_budget_lru_cache_index sblc_checker #(.MAX_ENTRIES(MAX_ENTRIES)) u_sblc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .is_eviction_o  (is_eviction_o),
  .ok_o           (ok_o),
  .out_hash_o     (out_hash_o),
  .used_entries_o (used_entries_o),
  .last_o         (last_o)
);
`default_nettype wire
